@@ hw/rtl/sodo_pkg.sv @@
// Shared types and constants of the Simpson odometer integrator.
package sodo_pkg;

   localparam int unsigned ODO_W     = 48;
   localparam int unsigned TRIP_W    = 40;
   localparam int unsigned SESSION_W = 48;
   localparam int unsigned UNSAVED_W = 33;
   localparam int unsigned STEP_W    = 32;
   localparam int unsigned SUM_W     = 22;
   localparam int unsigned SPEED_W   = 16;
   localparam int unsigned IDX_W     = 5;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [TRIP_W-1:0] TRIP_LIMIT_RESET = 40'd21600000000;
   localparam logic [STEP_W-1:0] SAVE_STEP_RESET  = 32'd2160000;

   typedef enum logic [1:0] {
      MODE_SPEED      = 2'd0,
      MODE_CLEAR_TRIP = 2'd1,
      MODE_CLEAR_ALL  = 2'd2,
      MODE_LOAD       = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ODO_PRESET  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_PRESET = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_LIMIT  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_STEP   = 8'd3;

   typedef struct packed {
      logic [ODO_W-1:0]  odo_preset;
      logic [TRIP_W-1:0] trip_preset;
      logic [TRIP_W-1:0] trip_limit;
      logic [STEP_W-1:0] save_step;
   } cfg_type;

   // Window closure seen by the accumulators.
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] distance;
   } win_type;

   typedef struct packed {
      logic [SESSION_W-1:0] session;
      logic [TRIP_W-1:0]    trip;
      logic [ODO_W-1:0]     odometer;
   } totals_type;

   typedef struct packed {
      logic save_request;
      logic window_done;
   } flags_type;

endpackage

@@ hw/rtl/sodo_window.sv @@
// Running Simpson weighted sum over one integration window.
module sodo_window import sodo_pkg::*; #(
   parameter int unsigned WINDOW_SAMPLES = 21
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [SPEED_W-1:0] speed,
   output win_type            win
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] v;
   logic [SUM_W-1:0] weighted;

   // Negative speeds count as standing still.
   assign v = speed[SPEED_W-1] ? '0 : SUM_W'(speed[SPEED_W-2:0]);

   always_comb begin
      if (idx_ff == '0) begin
         weighted = v;
      end else if (idx_ff[0]) begin
         weighted = {v[SUM_W-3:0], 2'b00};
      end else begin
         weighted = {v[SUM_W-2:0], 1'b0};
      end
   end

   always_comb begin
      win.done     = 1'b0;
      win.distance = sum_ff + v;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      if (step) begin
         if (idx_ff >= LAST_IDX) begin
            // The closing sample opens the next window with weight one.
            win.done = 1'b1;
            sum_in   = v;
            idx_in   = IDX_W'(1);
         end else begin
            sum_in = sum_ff + weighted;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
      end
   end

endmodule

@@ hw/rtl/sodo_accum.sv @@
// Odometer, trip, session and unsaved distance accumulators.
module sodo_accum import sodo_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  mode_type   mode,
   input  win_type    win,
   input  cfg_type    cfg,
   output totals_type totals,
   output flags_type  flags
);

   logic [ODO_W-1:0]     odo_ff, odo_in;
   logic [TRIP_W-1:0]    trip_ff, trip_in;
   logic [SESSION_W-1:0] session_ff, session_in;
   logic [UNSAVED_W-1:0] unsaved_ff, unsaved_in;

   logic [ODO_W:0]       odo_sum;
   logic [TRIP_W:0]      trip_sum;
   logic [SESSION_W:0]   session_sum;
   logic [UNSAVED_W:0]   unsaved_sum;
   logic [ODO_W-1:0]     odo_sat;
   logic [TRIP_W-1:0]    trip_sat;
   logic [SESSION_W-1:0] session_sat;
   logic [UNSAVED_W-1:0] unsaved_sat;
   logic [UNSAVED_W-1:0] step_ext;

   assign odo_sum     = {1'b0, odo_ff} + (ODO_W+1)'(win.distance);
   assign trip_sum    = {1'b0, trip_ff} + (TRIP_W+1)'(win.distance);
   assign session_sum = {1'b0, session_ff} + (SESSION_W+1)'(win.distance);
   assign unsaved_sum = {1'b0, unsaved_ff} + (UNSAVED_W+1)'(win.distance);

   assign odo_sat     = odo_sum[ODO_W] ? '1 : odo_sum[ODO_W-1:0];
   assign trip_sat    = trip_sum[TRIP_W] ? '1 : trip_sum[TRIP_W-1:0];
   assign session_sat = session_sum[SESSION_W] ? '1 : session_sum[SESSION_W-1:0];
   assign unsaved_sat = unsaved_sum[UNSAVED_W] ? '1 : unsaved_sum[UNSAVED_W-1:0];
   assign step_ext    = UNSAVED_W'(cfg.save_step);

   always_comb begin
      odo_in             = odo_ff;
      trip_in            = trip_ff;
      session_in         = session_ff;
      unsaved_in         = unsaved_ff;
      flags.window_done  = 1'b0;
      flags.save_request = 1'b0;
      unique case (mode)
         MODE_SPEED: begin
            if (win.done) begin
               flags.window_done = 1'b1;
               odo_in            = odo_sat;
               session_in        = session_sat;
               // The trip wraps to zero once it reaches its limit.
               trip_in = (trip_sat >= cfg.trip_limit) ? '0 : trip_sat;
               if (unsaved_sat >= step_ext) begin
                  unsaved_in         = unsaved_sat - step_ext;
                  flags.save_request = 1'b1;
               end else begin
                  unsaved_in = unsaved_sat;
               end
            end
         end
         MODE_CLEAR_TRIP: begin
            trip_in            = '0;
            flags.save_request = 1'b1;
         end
         MODE_CLEAR_ALL: begin
            odo_in             = '0;
            trip_in            = '0;
            flags.save_request = 1'b1;
         end
         MODE_LOAD: begin
            odo_in     = cfg.odo_preset;
            trip_in    = cfg.trip_preset;
            session_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign totals.odometer = odo_in;
   assign totals.trip     = trip_in;
   assign totals.session  = session_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         odo_ff     <= '0;
         trip_ff    <= '0;
         session_ff <= '0;
         unsaved_ff <= '0;
      end else if (step) begin
         odo_ff     <= odo_in;
         trip_ff    <= trip_in;
         session_ff <= session_in;
         unsaved_ff <= unsaved_in;
      end
   end

endmodule

@@ hw/rtl/simpson_odometer_integrator.sv @@
// Top level of the Simpson-rule odometer integrator.
// A request is accepted into the input stage; its result is then registered into the result stage.
// Throughput: one request per cycle while rsp_tready does not hold the result stage;
// window and accumulator state update as each request advances, so back-to-back requests do not wait on each other.
// Reset (synchronous) clears all sums and counters, loads the register
// defaults and empties both pipeline stages; no clearing pass is needed.
module simpson_odometer_integrator import sodo_pkg::*; #(
   parameter int unsigned WINDOW_SAMPLES = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // speed[15:0]
   input  logic [1:0]            req_tuser,  // mode[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [135:0]          rsp_tdata,  // odometer[47:0], trip[87:48], session[135:88]
   output logic [1:0]            rsp_tuser,  // window_done[0], save_request[1]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic               in_valid_ff;
   mode_type           in_mode_ff;
   logic [SPEED_W-1:0] in_speed_ff;
   logic               advance;
   logic               rsp_valid_ff;
   totals_type         rsp_totals_ff;
   flags_type          rsp_flags_ff;
   cfg_type            cfg_ff;
   win_type            win;
   totals_type         totals;
   flags_type          flags;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_mode_ff  <= mode_type'(req_tuser);
         in_speed_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.odo_preset  <= '0;
         cfg_ff.trip_preset <= '0;
         cfg_ff.trip_limit  <= TRIP_LIMIT_RESET;
         cfg_ff.save_step   <= SAVE_STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ODO_PRESET:  cfg_ff.odo_preset  <= csr_data[ODO_W-1:0];
            CSR_TRIP_PRESET: cfg_ff.trip_preset <= csr_data[TRIP_W-1:0];
            CSR_TRIP_LIMIT:  cfg_ff.trip_limit  <= csr_data[TRIP_W-1:0];
            CSR_SAVE_STEP:   cfg_ff.save_step   <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sodo_window #(
      .WINDOW_SAMPLES(WINDOW_SAMPLES)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .step  (advance && (in_mode_ff == MODE_SPEED)),
      .speed (in_speed_ff),
      .win   (win)
   );

   sodo_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .mode   (in_mode_ff),
      .win    (win),
      .cfg    (cfg_ff),
      .totals (totals),
      .flags  (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_totals_ff <= totals;
         rsp_flags_ff  <= flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_totals_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

@@ hw/rtl/sodo_checker.sv @@
// Port-level checks of the odometer integrator and their binding.
module sodo_checker import sodo_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [135:0]          rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // A result waiting for the sink keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A save request without a closed window comes from a clear, so the trip is zero.
   a_clear_trip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] && !rsp_tuser[0] |-> rsp_tdata[87:48] == 40'd0)
      else $error("clear left a nonzero trip");

   // Reset empties the result stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With the result stage free, the block takes a new request.
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && !$past(req_tvalid) |-> req_tready)
      else $error("request refused while the block was empty");

endmodule

bind simpson_odometer_integrator sodo_checker u_sodo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/sv/tb_simpson_odometer_integrator.sv @@
// Self-checking testbench of the Simpson-rule odometer integrator.

class odometer_scoreboard;
   typedef logic [49:0] wide_type;

   typedef struct {
      logic [sodo_pkg::ODO_W-1:0]     odometer;
      logic [sodo_pkg::TRIP_W-1:0]    trip;
      logic [sodo_pkg::SESSION_W-1:0] session;
      logic                           window_done;
      logic                           save_request;
   } record_type;

   logic [sodo_pkg::ODO_W-1:0]     odo_preset;
   logic [sodo_pkg::TRIP_W-1:0]    trip_preset;
   logic [sodo_pkg::TRIP_W-1:0]    trip_limit;
   logic [sodo_pkg::STEP_W-1:0]    save_step;

   logic [sodo_pkg::SUM_W-1:0]     weighted_sum;
   logic [sodo_pkg::IDX_W-1:0]     sample_index;
   logic [sodo_pkg::ODO_W-1:0]     odo_total;
   logic [sodo_pkg::TRIP_W-1:0]    trip_total;
   logic [sodo_pkg::SESSION_W-1:0] session_total;
   logic [sodo_pkg::UNSAVED_W-1:0] unsaved_total;

   record_type expected_q[$];
   int window_samples;
   int errors, checked, windows, saves, trip_wraps, saturations;

   function new(int samples);
      window_samples = samples;
      odo_preset     = '0;
      trip_preset    = '0;
      trip_limit     = sodo_pkg::TRIP_LIMIT_RESET;
      save_step      = sodo_pkg::SAVE_STEP_RESET;
      weighted_sum   = '0;
      sample_index   = '0;
      odo_total      = '0;
      trip_total     = '0;
      session_total  = '0;
      unsaved_total  = '0;
      errors         = 0;
      checked        = 0;
      windows        = 0;
      saves          = 0;
      trip_wraps     = 0;
      saturations    = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void write_register(logic [sodo_pkg::CSR_IDX_W-1:0] index,
                                logic [sodo_pkg::CSR_DATA_W-1:0] value);
      case (index)
         sodo_pkg::CSR_ODO_PRESET:  odo_preset  = value[sodo_pkg::ODO_W-1:0];
         sodo_pkg::CSR_TRIP_PRESET: trip_preset = value[sodo_pkg::TRIP_W-1:0];
         sodo_pkg::CSR_TRIP_LIMIT:  trip_limit  = value[sodo_pkg::TRIP_W-1:0];
         sodo_pkg::CSR_SAVE_STEP:   save_step   = value[sodo_pkg::STEP_W-1:0];
         default: ;
      endcase
   endfunction

   function wide_type all_ones(int width);
      return (wide_type'(1) << width) - wide_type'(1);
   endfunction

   function wide_type add_saturate(wide_type a, wide_type b, int width);
      wide_type s;
      s = a + b;
      if (s > all_ones(width)) begin
         saturations++;
         return all_ones(width);
      end
      return s;
   endfunction

   // Works out the totals and flags that one accepted request must produce.
   function void note_request(sodo_pkg::mode_type mode, logic [sodo_pkg::SPEED_W-1:0] speed);
      logic [sodo_pkg::SPEED_W-1:0] v;
      logic [sodo_pkg::SUM_W-1:0]   span;
      logic [sodo_pkg::SUM_W-1:0]   weight;
      record_type                   rec;
      rec.window_done  = 1'b0;
      rec.save_request = 1'b0;
      case (mode)
         sodo_pkg::MODE_SPEED: begin
            v = speed[sodo_pkg::SPEED_W-1] ? '0 : speed;
            if (int'(sample_index) >= window_samples - 1) begin
               span = weighted_sum + sodo_pkg::SUM_W'(v);
               odo_total = sodo_pkg::ODO_W'(add_saturate(wide_type'(odo_total),
                                                         wide_type'(span), sodo_pkg::ODO_W));
               trip_total = sodo_pkg::TRIP_W'(add_saturate(wide_type'(trip_total),
                                                           wide_type'(span), sodo_pkg::TRIP_W));
               session_total = sodo_pkg::SESSION_W'(add_saturate(wide_type'(session_total),
                                                   wide_type'(span), sodo_pkg::SESSION_W));
               unsaved_total = sodo_pkg::UNSAVED_W'(add_saturate(wide_type'(unsaved_total),
                                                   wide_type'(span), sodo_pkg::UNSAVED_W));
               if (trip_total >= trip_limit) begin
                  trip_total = '0;
                  trip_wraps++;
               end
               if (unsaved_total >= sodo_pkg::UNSAVED_W'(save_step)) begin
                  unsaved_total = unsaved_total - sodo_pkg::UNSAVED_W'(save_step);
                  rec.save_request = 1'b1;
               end
               // The closing sample opens the next window with weight one.
               weighted_sum    = sodo_pkg::SUM_W'(v);
               sample_index    = sodo_pkg::IDX_W'(1);
               rec.window_done = 1'b1;
               windows++;
            end else begin
               if (sample_index == '0)
                  weight = sodo_pkg::SUM_W'(1);
               else if (sample_index[0])
                  weight = sodo_pkg::SUM_W'(4);
               else
                  weight = sodo_pkg::SUM_W'(2);
               weighted_sum = weighted_sum + weight * sodo_pkg::SUM_W'(v);
               sample_index = sample_index + sodo_pkg::IDX_W'(1);
            end
         end
         sodo_pkg::MODE_CLEAR_TRIP: begin
            trip_total       = '0;
            rec.save_request = 1'b1;
         end
         sodo_pkg::MODE_CLEAR_ALL: begin
            odo_total        = '0;
            trip_total       = '0;
            rec.save_request = 1'b1;
         end
         default: begin
            odo_total     = odo_preset;
            trip_total    = trip_preset;
            session_total = '0;
         end
      endcase
      if (rec.save_request)
         saves++;
      rec.odometer = odo_total;
      rec.trip     = trip_total;
      rec.session  = session_total;
      expected_q.push_back(rec);
   endfunction

   function void compare_field(string name, logic [47:0] want, logic [47:0] got, realtime now);
      if (got !== want) begin
         errors++;
         $display("%0.3f ns: %s mismatch, expected %0d, actual %0d", now, name, want, got);
      end
   endfunction

   function void check_response(logic [135:0] data, logic [1:0] flags, realtime now);
      record_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0.3f ns: response with no request outstanding, expected none, actual %h/%b",
                  now, data, flags);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("odometer", 48'(want.odometer), 48'(data[47:0]), now);
      compare_field("trip", 48'(want.trip), 48'(data[87:48]), now);
      compare_field("session", 48'(want.session), 48'(data[135:88]), now);
      compare_field("window_done", 48'(want.window_done), 48'(flags[0]), now);
      compare_field("save_request", 48'(want.save_request), 48'(flags[1]), now);
   endfunction
endclass

module tb_simpson_odometer_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   import sodo_pkg::*;

   localparam int unsigned WINDOW_SAMPLES = 21;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned PHASE_ITEMS    = 285;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [135:0]          rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   bit hold_request    = 1'b0;
   bit quiet_tail      = 1'b0;
   int sender_gap_odds = 0;
   int requests_sent   = 0;

   odometer_scoreboard odo_board;

   simpson_odometer_integrator #(
      .WINDOW_SAMPLES(WINDOW_SAMPLES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         odo_board.check_response(rsp_tdata, rsp_tuser, $realtime);
   end

   // Result side: calm stretches alternate with stretches of random stalls.
   initial begin
      int calm_left;
      int stall_odds;
      int stall_len;
      calm_left  = 0;
      stall_odds = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            if (calm_left == 0) begin
               calm_left  = $urandom_range(20, 120);
               stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
            end
            calm_left--;
            if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
               stall_len = $urandom_range(1, 12);
               rsp_tready <= 1'b0;
               repeat (stall_len) @(posedge clock);
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic send_request(input mode_type mode, input logic [15:0] speed);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= speed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      odo_board.note_request(mode, speed);
      requests_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      odo_board.write_register(index, value);
   endtask

   task automatic program_registers(input logic [47:0] odo, input logic [39:0] trip,
                                    input logic [39:0] limit, input logic [31:0] step);
      write_csr(CSR_ODO_PRESET, odo);
      write_csr(CSR_TRIP_PRESET, 48'(trip));
      write_csr(CSR_TRIP_LIMIT, 48'(limit));
      write_csr(CSR_SAVE_STEP, 48'(step));
      csr_valid <= 1'b0;
   endtask

   // Every request yields a result, so an empty queue plus the pipeline depth means idle.
   task automatic wait_drained();
      while (odo_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int clear_pct, input int load_pct,
                            input int pressure_at);
      mode_type    mode;
      logic [15:0] speed;
      int          pick;
      int          k;
      bit          pressing;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (k == 0 || pick < load_pct)
            mode = MODE_LOAD;
         else if (pick < load_pct + clear_pct)
            mode = MODE_CLEAR_TRIP;
         else if (pick < load_pct + 2 * clear_pct)
            mode = MODE_CLEAR_ALL;
         else
            mode = MODE_SPEED;
         pick = $urandom_range(0, 9);
         if (pick < 4)
            speed = 16'($urandom);
         else if (pick < 8)
            speed = 16'($urandom_range(20000, 32767));
         else if (pick == 8)
            speed = 16'($urandom_range(0, 64));
         else
            speed = 16'h8000 | 16'($urandom);
         if (pressure_at != 0 && k == pressure_at)
            hold_request = 1'b1;
         pressing = pressure_at != 0 && k >= pressure_at && k < pressure_at + 2 * HOLD_CYCLES;
         send_request(mode, speed);
         // The sender keeps offering while the result side holds off.
         if (!pressing && sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      int i;
      odo_board = new(WINDOW_SAMPLES);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // One full window at the register defaults, with the speed extremes up front.
      send_request(MODE_SPEED, 16'h7FFF);
      send_request(MODE_SPEED, 16'h8000);
      send_request(MODE_SPEED, 16'hFFFF);
      send_request(MODE_SPEED, 16'h0000);
      send_request(MODE_SPEED, 16'h0001);
      for (i = 5; i < WINDOW_SAMPLES; i++)
         send_request(MODE_SPEED, 16'h7FFF);
      send_request(MODE_CLEAR_TRIP, 16'h7FFF);
      send_request(MODE_CLEAR_ALL, 16'h0000);
      send_request(MODE_LOAD, 16'hFFFF);
      send_request(MODE_SPEED, 16'h1234);
      req_tvalid <= 1'b0;
      wait_drained();

      // Small limit and step, so the trip wraps and saves fire often.
      sender_gap_odds = 4;
      program_registers({16'($urandom), 32'($urandom)}, 40'($urandom_range(0, 2000000)),
                        40'($urandom_range(1000000, 8000000)),
                        32'($urandom_range(1, 3000000)));
      run_phase(PHASE_ITEMS, 4, 3, 0);

      // Presets just under the top, widest limit and step: saturation at full width.
      sender_gap_odds = 8;
      program_registers(48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4000000)),
                        40'hFF_FFFF_FFFF - 40'($urandom_range(0, 3000000)),
                        40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(PHASE_ITEMS, 1, 3, 0);

      // Smallest limit and step.
      sender_gap_odds = 3;
      program_registers(48'd0, 40'd0, 40'd1, 32'd1);
      run_phase(PHASE_ITEMS, 4, 3, 0);

      // Random registers, with one long hold-off on the result side.
      sender_gap_odds = 6;
      program_registers({16'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)},
                        {8'($urandom), 32'($urandom)} | 40'd1, 32'($urandom) | 32'd1);
      run_phase(PHASE_ITEMS, 4, 3, 100);

      // Back to the default limit and step with the trip near its limit, no idling.
      quiet_tail      = 1'b1;
      sender_gap_odds = 0;
      program_registers(48'd0, TRIP_LIMIT_RESET - 40'd5000000, TRIP_LIMIT_RESET,
                        SAVE_STEP_RESET);
      run_phase(PHASE_ITEMS, 2, 2, 0);

      $display("Sent %0d requests over the defaults and five register settings, %0d checked.",
               requests_sent, odo_board.checked);
      $display("Windows closed %0d, save requests %0d, trip wraps %0d, saturated sums %0d.",
               odo_board.windows, odo_board.saves, odo_board.trip_wraps,
               odo_board.saturations);
      if (odo_board.errors == 0 && odo_board.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
